// ===== src/weekday_alarm_dose_scheduler_unit_macros.svh =====
// Assertion macros used by the dose scheduler controller.
`ifndef WEEKDAY_ALARM_DOSE_SCHEDULER_UNIT_MACROS_SVH
`define WEEKDAY_ALARM_DOSE_SCHEDULER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define WADS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("scheduler check failed");

// Next-cycle implication, disabled during reset.
`define WADS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("scheduler check failed");

`endif

// ===== src/wads_pkg.sv =====
// Types, codes and helper functions of the dose scheduler.
`timescale 1ns / 1ps
package wads_pkg;

  localparam int unsigned CountW = 3;
  localparam logic [4:0] MaxHour = 5'd23;
  localparam logic [5:0] MaxMinute = 6'd59;
  localparam logic [4:0] NoonHour = 5'd12;
  localparam logic [3:0] MaxSlot = 4'd14;
  localparam logic [2:0] NoWeekday = 3'd7;
  localparam logic [2:0] Sunday = 3'd0;
  localparam logic [2:0] SundayAdj = 3'd6;
  localparam logic [11:0] StepsReset = 12'd2048;
  localparam logic [5:0] WindowReset = 6'd5;

  typedef enum logic [2:0] {
    CmdTick     = 3'd0,
    CmdAdd      = 3'd1,
    CmdDelete   = 3'd2,
    CmdClear    = 3'd3,
    CmdDispense = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    KindAccepted  = 3'd0,
    KindRejected  = 3'd1,
    KindScheduled = 3'd2,
    KindManual    = 3'd3,
    KindNone      = 3'd4
  } kind_e;

  typedef enum logic {
    CfgStepsPerSlot  = 1'b0,
    CfgTriggerWindow = 1'b1
  } cfg_e;

  typedef struct packed {
    logic [2:0] command;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [2:0] weekday;
    logic [7:0] day_mask;
    logic [7:0] dose_count;
    logic [2:0] entry_index;
  } wads_in_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  alarm_number;
    logic [3:0]  slot;
    logic [15:0] steps_to_slot;
    logic [7:0]  doses_out;
    logic        last;
  } wads_out_t;

  // Controller to datapath.
  typedef struct packed {
    logic latch;
    logic exec;
    logic scan;
    logic emit;
  } wads_ctl_t;

  // Datapath to controller.
  typedef struct packed {
    logic is_tick;
    logic emit_last;
  } wads_sts_t;

  // Compartment from weekday and AM/PM; Sunday maps to the last day pair.
  function automatic logic [3:0] slot_for(logic [2:0] weekday, logic [4:0] hour);
    logic [2:0] adj;
    logic [4:0] s;
    adj = (weekday == Sunday) ? SundayAdj : weekday - 3'd1;
    s = 5'd1 + {1'b0, adj, 1'b0} + {4'd0, (hour < NoonHour)};
    if (s > {1'b0, MaxSlot}) begin
      s = {1'b0, MaxSlot};
    end
    return s[3:0];
  endfunction

endpackage

// ===== src/wads_ctrl.sv =====
// Sequencing state machine of the dose scheduler.
`timescale 1ns / 1ps
`include "weekday_alarm_dose_scheduler_unit_macros.svh"
module wads_ctrl
  import wads_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  wads_sts_t sts_i,
  output wads_ctl_t ctl_o,
  output logic      busy_o,
  output logic      result_valid_o
);

  typedef enum logic [1:0] {
    StIdle,
    StRun,
    StEmit
  } state_e;

  state_e state_q, state_d;
  logic   result_valid_q, result_valid_d;

  always_comb begin
    state_d        = state_q;
    result_valid_d = 1'b0;
    ctl_o          = '0;
    case (state_q)
      StIdle: begin
        if (start_i) begin
          ctl_o.latch = 1'b1;
          state_d     = StRun;
        end
      end
      StRun: begin
        if (sts_i.is_tick) begin
          ctl_o.scan = 1'b1;
          state_d    = StEmit;
        end else begin
          ctl_o.exec     = 1'b1;
          result_valid_d = 1'b1;
          state_d        = StIdle;
        end
      end
      StEmit: begin
        ctl_o.emit     = 1'b1;
        result_valid_d = 1'b1;
        if (sts_i.emit_last) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= StIdle;
      result_valid_q <= 1'b0;
    end else begin
      state_q        <= state_d;
      result_valid_q <= result_valid_d;
    end
  end

  assign busy_o         = (state_q != StIdle);
  assign result_valid_o = result_valid_q;

  `WADS_ASSERT_NEXT(a_start_runs, (state_q == StIdle) && start_i, state_q == StRun)
  `WADS_ASSERT_NEXT(a_emit_strobes, state_q == StEmit, result_valid_q)
  `WADS_ASSERT_NEXT(a_cmd_one_result, (state_q == StRun) && !sts_i.is_tick,
                    result_valid_q && (state_q == StIdle))
  `WADS_ASSERT_NOW(a_strobe_source, result_valid_q,
                   $past(state_q) == StRun || $past(state_q) == StEmit)

endmodule

// ===== src/wads_datapath.sv =====
// Alarm table, fire logic and result register of the dose scheduler.
`timescale 1ns / 1ps
module wads_datapath
  import wads_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 7
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  wads_ctl_t  ctl_i,
  output wads_sts_t  sts_o,
  input  wads_in_t   cmd_i,
  input  logic       cfg_we_i,
  input  logic       cfg_index_i,
  input  logic [11:0] cfg_data_i,
  output wads_out_t  result_o
);

  localparam int unsigned IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  wads_in_t    in_q, in_d;
  wads_out_t   res_q, res_d;
  logic [11:0] steps_q, steps_d;
  logic [5:0]  window_q, window_d;

  logic [4:0] hour_q [TABLE_DEPTH];
  logic [5:0] min_q [TABLE_DEPTH];
  logic [6:0] days_q [TABLE_DEPTH];
  logic [7:0] doses_q [TABLE_DEPTH];
  logic [4:0] hour_d [TABLE_DEPTH];
  logic [5:0] min_d [TABLE_DEPTH];
  logic [6:0] days_d [TABLE_DEPTH];
  logic [7:0] doses_d [TABLE_DEPTH];

  logic [CountW-1:0]      count_q, count_d;
  logic [TABLE_DEPTH-1:0] fired_q, fired_d;
  logic [TABLE_DEPTH-1:0] pend_q, pend_d;
  logic [2:0]             last_wd_q, last_wd_d;

  logic [TABLE_DEPTH-1:0] af_base, fire, min_eq, pick, rest;
  logic [7:0]             day_ext [TABLE_DEPTH];
  logic [IdxW-1:0]        sel;
  logic [3:0]             res_slot;
  logic                   add_ok;

  // Fire check of every entry in parallel; day change rearms first.
  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      af_base[i] = (in_q.weekday != last_wd_q) ? 1'b0 : fired_q[i];
      min_eq[i]  = (min_q[i] == in_q.minute);
      // Pad the mask so that the out-of-range day selects a zero bit.
      day_ext[i] = {1'b0, days_q[i]};
      fire[i]    = (3'(i) < count_q) && day_ext[i][in_q.weekday] &&
                   (hour_q[i] == in_q.hour) && min_eq[i] &&
                   (in_q.second <= window_q) && !af_base[i];
    end
  end

  // Lowest pending alarm goes out first.
  always_comb begin
    sel  = '0;
    pick = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (pend_q[i]) begin
        sel  = IdxW'(i);
        pick = '0;
        pick[i] = 1'b1;
      end
    end
    rest = pend_q & ~pick;
  end

  assign add_ok = (count_q < CountW'(TABLE_DEPTH)) && (in_q.hour <= MaxHour) &&
                  (in_q.minute <= MaxMinute) && (in_q.dose_count != '0) &&
                  (in_q.day_mask != '0);

  always_comb begin
    in_d      = in_q;
    steps_d   = steps_q;
    window_d  = window_q;
    count_d   = count_q;
    fired_d   = fired_q;
    pend_d    = pend_q;
    last_wd_d = last_wd_q;
    hour_d    = hour_q;
    min_d     = min_q;
    days_d    = days_q;
    doses_d   = doses_q;
    res_d     = res_q;
    res_slot  = '0;

    if (cfg_we_i) begin
      case (cfg_index_i)
        CfgStepsPerSlot:  steps_d  = cfg_data_i;
        CfgTriggerWindow: window_d = cfg_data_i[5:0];
        default: ;
      endcase
    end

    if (ctl_i.latch) begin
      in_d = cmd_i;
    end

    if (ctl_i.exec) begin
      res_d      = '0;
      res_d.last = 1'b1;
      case (in_q.command)
        CmdAdd: begin
          if (add_ok) begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
              if (3'(i) == count_q) begin
                hour_d[i]  = in_q.hour;
                min_d[i]   = in_q.minute;
                days_d[i]  = in_q.day_mask[6:0];
                doses_d[i] = in_q.dose_count;
              end
            end
            count_d    = count_q + 3'd1;
            fired_d    = '0;
            res_d.kind = KindAccepted;
          end else begin
            res_d.kind = KindRejected;
          end
        end
        CmdDelete: begin
          if (in_q.entry_index < count_q) begin
            // Shift later entries down by one.
            for (int i = 0; i < TABLE_DEPTH - 1; i++) begin
              if ((3'(i) >= in_q.entry_index) && (3'(i + 1) < count_q)) begin
                hour_d[i]  = hour_q[i + 1];
                min_d[i]   = min_q[i + 1];
                days_d[i]  = days_q[i + 1];
                doses_d[i] = doses_q[i + 1];
              end
            end
            count_d    = count_q - 3'd1;
            fired_d    = '0;
            res_d.kind = KindAccepted;
          end else begin
            res_d.kind = KindRejected;
          end
        end
        CmdClear: begin
          count_d    = '0;
          fired_d    = '0;
          res_d.kind = KindAccepted;
        end
        CmdDispense: begin
          res_slot        = slot_for(in_q.weekday, 5'd0);
          res_d.kind      = KindManual;
          res_d.slot      = res_slot;
          res_d.doses_out = (in_q.dose_count == '0) ? 8'd1 : in_q.dose_count;
        end
        default: begin
          res_d.kind = KindRejected;
        end
      endcase
    end

    if (ctl_i.scan) begin
      last_wd_d = in_q.weekday;
      pend_d    = fire;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        fired_d[i] = (3'(i) < count_q) ? ((af_base[i] | fire[i]) & min_eq[i])
                                       : af_base[i];
      end
    end

    if (ctl_i.emit) begin
      res_d = '0;
      if (pend_q != '0) begin
        res_slot           = slot_for(in_q.weekday, hour_q[sel]);
        res_d.kind         = KindScheduled;
        res_d.alarm_number = 3'(sel);
        res_d.slot         = res_slot;
        res_d.doses_out    = doses_q[sel];
        res_d.last         = (rest == '0);
      end else begin
        res_d.kind = KindNone;
        res_d.last = 1'b1;
      end
      pend_d = rest;
    end

    if (ctl_i.exec || ctl_i.emit) begin
      res_d.steps_to_slot = 16'(res_slot) * 16'(steps_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steps_q   <= StepsReset;
      window_q  <= WindowReset;
      count_q   <= '0;
      fired_q   <= '0;
      pend_q    <= '0;
      last_wd_q <= NoWeekday;
    end else begin
      steps_q   <= steps_d;
      window_q  <= window_d;
      count_q   <= count_d;
      fired_q   <= fired_d;
      pend_q    <= pend_d;
      last_wd_q <= last_wd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q    <= in_d;
    res_q   <= res_d;
    hour_q  <= hour_d;
    min_q   <= min_d;
    days_q  <= days_d;
    doses_q <= doses_d;
  end

  assign sts_o.is_tick   = (in_q.command == CmdTick);
  assign sts_o.emit_last = (rest == '0);
  assign result_o        = res_q;

endmodule

// ===== src/weekday_alarm_dose_scheduler_unit.sv =====
// Top level of the weekday alarm dose scheduler.
`timescale 1ns / 1ps
// Weekday alarm dose scheduler. Issue a command by raising start while busy
// is low; the transaction is taken at that clock edge. Tick, add, delete,
// clear and manual dispense commands are supported. Every result appears on
// result_o for exactly one cycle with result_valid_o high, and the receiver
// must take it then: there is no way to hold results off. The last result of
// a command carries last set. Add, delete, clear, dispense and unknown codes
// give one result, computed in the run state and registered. A tick compares
// all table entries in parallel against the current time, then gives one
// result per fired alarm, lowest first (at least one, a "nothing fired" result
// when none match). The next command may be issued in the cycle the final
// result is shown. The configuration port (steps per slot, trigger window) is
// always ready and must only be written while busy is low and no result is
// outstanding. The alarm table has no reset; only populated entries are ever
// read.
module weekday_alarm_dose_scheduler_unit
  import wads_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 7
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  wads_in_t    cmd_i,
  output logic        result_valid_o,
  output wads_out_t   result_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [11:0] cfg_data_i
);

  wads_ctl_t ctl;
  wads_sts_t sts;

  // Accept configuration writes at any time.
  assign cfg_ready_o = 1'b1;

  wads_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .sts_i          (sts),
    .ctl_o          (ctl),
    .busy_o         (busy),
    .result_valid_o (result_valid_o)
  );

  wads_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .cmd_i       (cmd_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .result_o    (result_o)
  );

endmodule
